// ----- hw/rtl/brf_pkg.sv -----
// Package for the byte ring FIFO with peek.
// Holds the command and result word types, function codes and state codes.
// No dependencies.
package brf_pkg;

  localparam int CW = 9;

  typedef enum logic [2:0] {
    FN_WRITE     = 3'd0,
    FN_READ      = 3'd1,
    FN_RUN_READ  = 3'd2,
    FN_RUN_WRITE = 3'd3,
    FN_PEEK      = 3'd4,
    FN_CLEAR     = 3'd5
  } brf_func_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } brf_state_t;

  typedef struct packed {
    logic [2:0]    func;
    logic [7:0]    data_in;
    logic [CW-1:0] run_length;
    logic          run_first;
    logic [7:0]    peek_offset;
  } brf_cmd_t;

  typedef struct packed {
    logic          ok;
    logic [7:0]    data_out;
    logic [CW-1:0] peek_next;
    logic [CW-1:0] fill_level;
    logic          last;
  } brf_rsp_t;

endpackage

// ----- hw/rtl/brf_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/byte_ring_fifo_with_peek_top.sv -----
// Top level of the byte ring FIFO with peek, run write and run read.
// Depends on brf_pkg and brf_ram.

// Each command word gives one result word, except a successful run read of one or more
// bytes, which gives one result word per byte with last set on the final one. Read and
// peek results come from the byte store, a RAM with a registered read port. In a run
// read the store is read at one address per cycle and the bytes stream out one per
// cycle behind the read, as long as the result port is not stalled. No command is taken
// while a read, peek or run read is still delivering. Writing the capacity register
// clears the FIFO; stored bytes are kept and the store needs no clearing pass
// after reset.
module byte_ring_fifo_with_peek_top #(
  parameter int DEPTH        = 256,
  parameter int MAX_RUN_READ = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  brf_pkg::brf_cmd_t          cmd,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output brf_pkg::brf_rsp_t          rsp,
  input  logic                       cfg_wen,
  input  logic [brf_pkg::CW-1:0]     cfg_wdata
);

  import brf_pkg::*;

  localparam int AW        = $clog2(DEPTH);
  localparam int PW        = (AW < CW) ? AW : CW;
  localparam int CapMax    = (DEPTH > 511) ? 511 : DEPTH;
  localparam int CapReset  = (CapMax < 256) ? CapMax : 256;
  localparam int RW        = (MAX_RUN_READ > 1) ? $clog2(MAX_RUN_READ) : 1;

  brf_state_t    state, state_next;
  logic [CW-1:0] cap, cap_next;
  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic [CW-1:0] held, held_next;
  logic          run_acc, run_acc_next;
  logic [CW-1:0] run_left, run_left_next;
  logic [PW-1:0] rptr, rptr_next;
  logic [RW-1:0] left, left_next;
  logic          pending, pending_next;
  logic          pend_last, pend_last_next;
  logic [CW-1:0] pend_pn, pend_pn_next;
  logic [CW-1:0] pend_fill, pend_fill_next;
  logic          rsp_valid_next;
  brf_rsp_t      rsp_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  logic          can_load;
  logic          accept;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] idx,
                                            input logic [CW-1:0] c);
    logic [CW:0] n;
    n = (CW+1)'(idx) + (CW+1)'(1);
    return (n >= {1'b0, c}) ? '0 : PW'(n);
  endfunction

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] idx,
                                             input logic [CW-1:0] off,
                                             input logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW+1)'(idx) + (CW+1)'(off);
    if (s >= {1'b0, c}) begin
      s = s - {1'b0, c};
    end
    return PW'(s);
  endfunction

  brf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign can_load  = !rsp_valid || !rsp_stall;
  assign cmd_stall = !((state == ST_IDLE) && can_load);
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cap       <= CW'(CapReset);
      head      <= '0;
      tail      <= '0;
      held      <= '0;
      run_acc   <= 1'b0;
      run_left  <= '0;
      left      <= '0;
      pending   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cap       <= cap_next;
      head      <= head_next;
      tail      <= tail_next;
      held      <= held_next;
      run_acc   <= run_acc_next;
      run_left  <= run_left_next;
      left      <= left_next;
      pending   <= pending_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rptr      <= rptr_next;
    pend_last <= pend_last_next;
    pend_pn   <= pend_pn_next;
    pend_fill <= pend_fill_next;
    rsp       <= rsp_next;
  end

  always_comb begin
    logic [CW-1:0] free;
    logic [CW-1:0] rlen;
    free           = cap - held;
    rlen           = cmd.run_length;
    state_next     = state;
    cap_next       = cap;
    head_next      = head;
    tail_next      = tail;
    held_next      = held;
    run_acc_next   = run_acc;
    run_left_next  = run_left;
    rptr_next      = rptr;
    left_next      = left;
    pending_next   = pending;
    pend_last_next = pend_last;
    pend_pn_next   = pend_pn;
    pend_fill_next = pend_fill;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    wr_en          = 1'b0;
    wr_addr        = AW'(tail);
    wr_data        = cmd.data_in;
    rd_en          = 1'b0;
    rd_addr        = AW'(head);

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          rsp_next            = '0;
          rsp_next.last       = 1'b1;
          rsp_next.fill_level = held;
          unique case (cmd.func)
            FN_WRITE: begin
              if (held < cap) begin
                wr_en               = 1'b1;
                tail_next           = advance(tail, cap);
                held_next           = held + CW'(1);
                rsp_next.ok         = 1'b1;
                rsp_next.fill_level = held + CW'(1);
              end
              rsp_valid_next = 1'b1;
            end
            FN_READ: begin
              if (held != '0) begin
                rd_en          = 1'b1;
                head_next      = advance(head, cap);
                held_next      = held - CW'(1);
                left_next      = '0;
                pending_next   = 1'b1;
                pend_last_next = 1'b1;
                pend_pn_next   = '0;
                pend_fill_next = held - CW'(1);
                state_next     = ST_READ;
              end else begin
                rsp_valid_next = 1'b1;
              end
            end
            FN_RUN_READ: begin
              if (held == '0 || rlen > held || rlen > CW'(MAX_RUN_READ)) begin
                rsp_valid_next = 1'b1;
              end else if (rlen == '0) begin
                rsp_next.ok    = 1'b1;
                rsp_valid_next = 1'b1;
              end else begin
                rd_en          = 1'b1;
                head_next      = wrap_add(head, rlen, cap);
                held_next      = held - rlen;
                rptr_next      = advance(head, cap);
                left_next      = RW'(rlen - CW'(1));
                pending_next   = 1'b1;
                pend_last_next = (rlen == CW'(1));
                pend_pn_next   = '0;
                pend_fill_next = held - rlen;
                state_next     = ST_READ;
              end
            end
            FN_RUN_WRITE: begin
              if (cmd.run_first) begin
                if (held >= cap || rlen == '0 || rlen > free) begin
                  run_acc_next  = 1'b0;
                  run_left_next = '0;
                end else begin
                  wr_en               = 1'b1;
                  tail_next           = advance(tail, cap);
                  held_next           = held + CW'(1);
                  rsp_next.ok         = 1'b1;
                  rsp_next.fill_level = held + CW'(1);
                  run_left_next       = rlen - CW'(1);
                  run_acc_next        = (rlen != CW'(1));
                end
              end else if (run_acc && run_left != '0) begin
                if (held < cap) begin
                  wr_en               = 1'b1;
                  tail_next           = advance(tail, cap);
                  held_next           = held + CW'(1);
                  rsp_next.ok         = 1'b1;
                  rsp_next.fill_level = held + CW'(1);
                  run_left_next       = run_left - CW'(1);
                  run_acc_next        = (run_left != CW'(1));
                end else begin
                  run_acc_next  = 1'b0;
                  run_left_next = '0;
                end
              end
              rsp_valid_next = 1'b1;
            end
            FN_PEEK: begin
              if (CW'(cmd.peek_offset) < held) begin
                rd_en          = 1'b1;
                rd_addr        = AW'(wrap_add(head, CW'(cmd.peek_offset), cap));
                left_next      = '0;
                pending_next   = 1'b1;
                pend_last_next = 1'b1;
                pend_pn_next   = CW'(cmd.peek_offset) + CW'(1);
                pend_fill_next = held;
                state_next     = ST_READ;
              end else begin
                rsp_next.peek_next = CW'(cmd.peek_offset);
                rsp_valid_next     = 1'b1;
              end
            end
            FN_CLEAR: begin
              head_next           = '0;
              tail_next           = '0;
              held_next           = '0;
              run_acc_next        = 1'b0;
              run_left_next       = '0;
              rsp_next.ok         = 1'b1;
              rsp_next.fill_level = '0;
              rsp_valid_next      = 1'b1;
            end
            default: begin
              rsp_valid_next = 1'b1;
            end
          endcase
        end
        if (cfg_wen) begin
          if (cfg_wdata == '0) begin
            cap_next = CW'(1);
          end else if ({1'b0, cfg_wdata} > (CW+1)'(CapMax)) begin
            cap_next = CW'(CapMax);
          end else begin
            cap_next = cfg_wdata;
          end
          head_next     = '0;
          tail_next     = '0;
          held_next     = '0;
          run_acc_next  = 1'b0;
          run_left_next = '0;
        end
      end
      ST_READ: begin
        if (pending && can_load) begin
          rsp_next.ok         = 1'b1;
          rsp_next.data_out   = rd_data;
          rsp_next.peek_next  = pend_pn;
          rsp_next.fill_level = pend_fill;
          rsp_next.last       = pend_last;
          rsp_valid_next      = 1'b1;
          pending_next        = 1'b0;
        end
        if (left != '0 && (!pending || can_load)) begin
          rd_en          = 1'b1;
          rd_addr        = AW'(rptr);
          rptr_next      = advance(rptr, cap);
          left_next      = left - RW'(1);
          pending_next   = 1'b1;
          pend_last_next = (left == RW'(1));
        end
        if (!pending_next && left_next == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- verif/brf_checker.sv -----
`timescale 1ns / 1ps
// Checker for the byte ring FIFO: watches the command, result and capacity ports,
// keeps its own ring model and compares every result word field by field.
// Depends on brf_pkg.
module brf_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  logic                   cmd_stall,
  input  brf_pkg::brf_cmd_t      cmd,
  input  logic                   rsp_valid,
  input  logic                   rsp_stall,
  input  brf_pkg::brf_rsp_t      rsp,
  input  logic                   cfg_wen,
  input  logic [brf_pkg::CW-1:0] cfg_wdata,
  output int                     fail_count,
  output int                     pending,
  output int                     words_checked
);

  import brf_pkg::*;

  localparam int RING_DEPTH   = 256;
  localparam int RUN_READ_MAX = 64;

  logic [7:0]    ring [RING_DEPTH];
  logic [CW-1:0] capacity_reg;
  int unsigned   head;
  int unsigned   tail;
  int unsigned   held;
  int unsigned   run_left;
  bit            run_open;
  int            mismatches;
  int            checked;
  brf_rsp_t      due_words [$];

  function automatic int unsigned ring_cap();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > RING_DEPTH) return RING_DEPTH;
    return 32'(capacity_reg);
  endfunction

  function automatic int unsigned step_index(int unsigned idx);
    return (idx + 1 >= ring_cap()) ? 0 : idx + 1;
  endfunction

  function automatic void empty_ring();
    head     = 0;
    tail     = 0;
    held     = 0;
    run_open = 1'b0;
    run_left = 0;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    ring[8'(tail)] = b;
    tail = step_index(tail);
    held++;
  endfunction

  function automatic logic [7:0] pop_byte();
    logic [7:0] b;
    b = ring[8'(head)];
    head = step_index(head);
    held--;
    return b;
  endfunction

  function automatic void queue_word(bit ok, logic [7:0] d, int unsigned pn, bit last);
    brf_rsp_t e;
    e.ok         = ok;
    e.data_out   = d;
    e.peek_next  = CW'(pn);
    e.fill_level = CW'(held);
    e.last       = last;
    due_words.push_back(e);
  endfunction

  function automatic void predict_word(brf_cmd_t w);
    int unsigned cap;
    int unsigned pos;
    int unsigned n;
    int          i;
    logic [7:0]  got [RUN_READ_MAX];
    bit          ok;
    logic [7:0]  d;
    int unsigned pn;
    cap = ring_cap();
    ok  = 1'b0;
    d   = '0;
    pn  = 0;
    n   = 32'(w.run_length);
    unique case (w.func)
      FN_WRITE: begin
        if (held < cap) begin
          push_byte(w.data_in);
          ok = 1'b1;
        end
      end
      FN_READ: begin
        if (held > 0) begin
          d  = pop_byte();
          ok = 1'b1;
        end
      end
      FN_RUN_READ: begin
        if (held != 0 && n <= held && n <= RUN_READ_MAX) begin
          ok = 1'b1;
          if (n != 0) begin
            for (i = 0; i < n; i++) got[6'(i)] = pop_byte();
            for (i = 0; i < n; i++) queue_word(1'b1, got[6'(i)], 0, i + 1 == n);
            return;
          end
        end
      end
      FN_RUN_WRITE: begin
        if (w.run_first) begin
          if (held >= cap || n == 0 || n > cap - held) begin
            run_open = 1'b0;
            run_left = 0;
          end else begin
            push_byte(w.data_in);
            ok       = 1'b1;
            run_left = n - 1;
            run_open = run_left != 0;
          end
        end else if (run_open && run_left > 0) begin
          if (held < cap) begin
            push_byte(w.data_in);
            ok = 1'b1;
            run_left--;
            if (run_left == 0) run_open = 1'b0;
          end else begin
            run_open = 1'b0;
            run_left = 0;
          end
        end
      end
      FN_PEEK: begin
        pn = 32'(w.peek_offset);
        if (32'(w.peek_offset) < held) begin
          pos = head + 32'(w.peek_offset);
          if (pos >= cap) pos -= cap;
          d  = ring[8'(pos)];
          pn = 32'(w.peek_offset) + 1;
          ok = 1'b1;
        end
      end
      FN_CLEAR: begin
        empty_ring();
        ok = 1'b1;
      end
      default: begin
      end
    endcase
    queue_word(ok, d, pn, 1'b1);
  endfunction

  function automatic void compare_word(brf_rsp_t got);
    brf_rsp_t want;
    if (due_words.size() == 0) begin
      $error("Result word with nothing expected: ok=%0d data_out=%0h peek_next=%0d",
             got.ok, got.data_out, got.peek_next);
      mismatches++;
      return;
    end
    want = due_words.pop_front();
    checked++;
    if (got.ok !== want.ok) begin
      $error("ok: expected %0d, got %0d", want.ok, got.ok);
      mismatches++;
    end
    if (got.data_out !== want.data_out) begin
      $error("data_out: expected %0h, got %0h", want.data_out, got.data_out);
      mismatches++;
    end
    if (got.peek_next !== want.peek_next) begin
      $error("peek_next: expected %0d, got %0d", want.peek_next, got.peek_next);
      mismatches++;
    end
    if (got.fill_level !== want.fill_level) begin
      $error("fill_level: expected %0d, got %0d", want.fill_level, got.fill_level);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      capacity_reg = CW'(RING_DEPTH);
      empty_ring();
      due_words.delete();
    end else begin
      if (cfg_wen) begin
        capacity_reg = cfg_wdata;
        empty_ring();
      end
      if (cmd_valid && !cmd_stall) predict_word(cmd);
      if (rsp_valid && !rsp_stall) compare_word(rsp);
    end
    fail_count    <= mismatches;
    pending       <= due_words.size();
    words_checked <= checked;
  end

endmodule

// ----- verif/tb_byte_ring_fifo_with_peek_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the byte ring FIFO with peek: drives directed and random command
// words under random idling and capacity changes, and gives the verdict.
// Depends on brf_pkg, byte_ring_fifo_with_peek_top and brf_checker.
module tb_byte_ring_fifo_with_peek_top;
  import brf_pkg::*;

  localparam logic [2:0] FN_SPARE_A    = 3'd6;
  localparam logic [2:0] FN_SPARE_B    = 3'd7;
  localparam int         MAX_WAIT      = 12;
  localparam int         FULL_CAPACITY = 256;

  logic          clk;
  logic          rst;
  logic          cmd_valid;
  logic          cmd_stall;
  brf_cmd_t      cmd;
  logic          rsp_valid;
  logic          rsp_stall;
  brf_rsp_t      rsp;
  logic          cfg_wen;
  logic [CW-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int words_checked;
  int words_sent;
  int settings_used;
  bit send_eager;
  bit take_eager;

  byte_ring_fifo_with_peek_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  brf_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #8ms;
    $display("tb_byte_ring_fifo_with_peek_top failed");
    $finish;
  end

  // After each result word is taken, the receiver may hold stall at random, but never while take_eager is set.
  initial begin
    int hold;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) begin
        hold = take_eager ? 0 : $urandom_range(0, MAX_WAIT);
        if (hold > 0) begin
          rsp_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          rsp_stall <= 1'b0;
        end
      end
    end
  end

  function automatic brf_cmd_t cmd_word(logic [2:0] f);
    brf_cmd_t w;
    w.func        = f;
    w.data_in     = 8'($urandom_range(0, 255));
    w.run_length  = CW'($urandom_range(0, 256));
    w.run_first   = 1'($urandom_range(0, 1));
    w.peek_offset = 8'($urandom_range(0, 255));
    return w;
  endfunction

  task automatic send_word(input brf_cmd_t w);
    int gap;
    gap = send_eager ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic do_op(logic [2:0] f);
    send_word(cmd_word(f));
  endtask

  task automatic put_byte(logic [7:0] b);
    brf_cmd_t w;
    w = cmd_word(FN_WRITE);
    w.data_in = b;
    send_word(w);
  endtask

  task automatic run_read(int n);
    brf_cmd_t w;
    w = cmd_word(FN_RUN_READ);
    w.run_length = CW'(n);
    send_word(w);
  endtask

  task automatic run_byte(bit first, int n, logic [7:0] b);
    brf_cmd_t w;
    w = cmd_word(FN_RUN_WRITE);
    w.run_first  = first;
    w.run_length = CW'(n);
    w.data_in    = b;
    send_word(w);
  endtask

  task automatic peek_at(int off);
    brf_cmd_t w;
    w = cmd_word(FN_PEEK);
    w.peek_offset = 8'(off);
    send_word(w);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(int v);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= CW'(v);
    @(posedge clk);
    cfg_wen <= 1'b0;
    settings_used++;
  endtask

  task automatic run_write_seq(int n);
    int i;
    int roll;
    run_byte(1'b1, n, 8'($urandom_range(0, 255)));
    for (i = 1; i < n && i < 40; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) return;
      if (roll < 10) put_byte(8'($urandom_range(0, 255)));
      run_byte(1'b0, $urandom_range(0, 256), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(int count);
    int stop_at;
    int roll;
    int pick;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) send_eager = !send_eager;
      if ($urandom_range(0, 19) == 0) take_eager = !take_eager;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (roll < 28) begin
        put_byte(8'($urandom_range(0, 255)));
      end else if (roll < 42) begin
        do_op(FN_READ);
      end else if (roll < 52) begin
        if (pick < 70) run_read($urandom_range(1, 8));
        else if (pick < 80) run_read(0);
        else if (pick < 90) run_read($urandom_range(60, 70));
        else run_read($urandom_range(0, 256));
      end else if (roll < 70) begin
        if (pick < 80) run_write_seq($urandom_range(1, 10));
        else if (pick < 95) run_write_seq($urandom_range(11, 40));
        else run_write_seq($urandom_range(0, 256));
      end else if (roll < 84) begin
        if (pick < 70) peek_at($urandom_range(0, 15));
        else peek_at($urandom_range(0, 255));
      end else if (roll < 90) begin
        run_byte(1'b0, $urandom_range(0, 256), 8'($urandom_range(0, 255)));
      end else if (roll < 95) begin
        do_op(FN_CLEAR);
      end else if (roll < 97) begin
        do_op(pick < 50 ? FN_SPARE_A : FN_SPARE_B);
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd        = '0;
    cfg_wen    = 1'b0;
    cfg_wdata  = '0;
    send_eager = 1'b0;
    take_eager = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do_op(FN_READ);
    run_read(0);
    peek_at(0);
    put_byte(8'h00);
    put_byte(8'hFF);
    peek_at(1);
    peek_at(2);
    peek_at(255);
    run_read(0);
    run_read(3);
    run_read(256);
    run_read(2);
    run_byte(1'b1, 0, 8'h11);
    run_byte(1'b0, 5, 8'h22);
    run_byte(1'b1, 3, 8'hA5);
    run_byte(1'b0, 0, 8'h5A);
    run_byte(1'b0, 0, 8'h3C);
    run_byte(1'b0, 0, 8'h77);
    do_op(FN_SPARE_A);
    do_op(FN_SPARE_B);
    peek_at(2);
    do_op(FN_CLEAR);
    run_byte(1'b1, 256, 8'h80);
    run_byte(1'b0, 0, 8'h01);
    do_op(FN_CLEAR);

    set_capacity(1);
    put_byte(8'h5A);
    put_byte(8'hA5);
    run_byte(1'b1, 1, 8'h01);
    peek_at(0);
    do_op(FN_READ);
    do_op(FN_READ);

    // A plain write takes the space reserved by the run, so the run is aborted.
    set_capacity(2);
    run_byte(1'b1, 2, 8'hC3);
    put_byte(8'h3C);
    run_byte(1'b0, 0, 8'h99);
    run_byte(1'b0, 0, 8'h98);
    run_byte(1'b1, 3, 8'h10);
    do_op(FN_READ);
    put_byte(8'hE7);
    peek_at(1);
    run_read(2);

    set_capacity(FULL_CAPACITY);
    send_eager = 1'b1;
    run_byte(1'b1, 66, 8'($urandom_range(0, 255)));
    repeat (65) run_byte(1'b0, $urandom_range(0, 256), 8'($urandom_range(0, 255)));
    run_read(65);
    run_read(64);
    send_eager = 1'b0;
    random_phase(8);

    set_capacity(1);
    random_phase(6);
    set_capacity(2);
    random_phase(6);
    set_capacity(7);
    random_phase(8);
    set_capacity(255);
    random_phase(8);
    set_capacity($urandom_range(3, 40));
    random_phase(8);
    set_capacity($urandom_range(1, FULL_CAPACITY));
    random_phase(8);

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d command words across %0d capacity settings; checked %0d result words.",
             words_sent, settings_used, words_checked);
    $display("Covered plain, run and peek access, refusals when full, empty or out of range,");
    $display("and pointer wrap at several capacities.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_byte_ring_fifo_with_peek_top passed");
    end else begin
      $display("tb_byte_ring_fifo_with_peek_top failed");
    end
    $finish;
  end

endmodule
